[hdl/kct_pkg.sv]
// Shared types, codes and arithmetic helpers for the keyed counter table.
package kct_pkg;

  localparam int unsigned ENTRIES_DEF  = 256;
  localparam int unsigned KEY_BITS_DEF = 20;

  localparam int unsigned KEY_W = 20;
  localparam int unsigned AMT_W = 16;
  localparam int unsigned CNT_W = 32;

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_RSVD   = 2'd3;

  // status codes
  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_EXEMPT = 2'd2;

  localparam logic signed [CNT_W-1:0] COUNT_MAX = 32'sh7fff_ffff;
  localparam logic signed [CNT_W-1:0] COUNT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [KEY_W-1:0]        key;
    logic signed [AMT_W-1:0] amount;
    logic                    exempt;
  } kct_in_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] count;
    logic                    found;
    logic [1:0]              status;
  } kct_out_t;

  // Signed add of amount to count, clamped to the 32-bit signed range.
  function automatic logic signed [CNT_W-1:0] sat_add(
    input logic signed [CNT_W-1:0] a,
    input logic signed [AMT_W-1:0] b
  );
    logic signed [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s[CNT_W] != s[CNT_W-1]) begin
      return s[CNT_W] ? COUNT_MIN : COUNT_MAX;
    end
    return s[CNT_W-1:0];
  endfunction

endpackage

[hdl/kct_ram.sv]
// Simple dual-port entry memory: one write port, one read port, registered read data.
module kct_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 52
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/keyed_counter_table_top.sv]
// Top level of the keyed counter table: command sequencer, occupancy and result register.
//
// Usage
//   Command channel: drive item_i and raise start_i; the command transfers at a
//   rising edge where start_i is high and busy_o is low. busy_o stays high while
//   the sequencer walks the table.
//   Result channel: done_o pulses for exactly one cycle with result_o valid.
//   The receiver cannot stall; it must take the result in that cycle.
//   The entry memory is read one entry per cycle through its single read
//   port, and that port sets the pace. Add or lookup stops at the slot that
//   hits; a miss reads every occupied slot. Remove then moves later entries
//   down through the same port, which has nothing to move when the last
//   entry goes.
//   Exempt add/lookup and the unused command finish without a search: done_o
//   pulses in the cycle after the transfer. The worst case is a remove of
//   the first entry of a full table.
//   busy_o drops in the same cycle that done_o rises, so the next command may
//   transfer while the previous result is shown.
//   Reset: occupancy clears to zero, the sequencer goes idle; memory contents
//   are left as they are, since only slots below occupancy are ever read.
module keyed_counter_table_top #(
  parameter int unsigned ENTRIES  = kct_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = kct_pkg::KEY_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  kct_pkg::kct_in_t item_i,
  output logic             done_o,
  output kct_pkg::kct_out_t result_o
);

  import kct_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned WORD_W = KEY_BITS + CNT_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_SHIFT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [OCC_W-1:0] occ_q, occ_d;
  logic [OCC_W-1:0] ridx_q, ridx_d;   // next slot to read
  logic [IDX_W-1:0] cidx_q, cidx_d;   // slot whose data sits on the read port
  logic             cvld_q, cvld_d;   // read data valid this cycle

  logic [1:0]              cmd_q, cmd_d;
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic signed [AMT_W-1:0] amt_q, amt_d;

  kct_out_t res_q, res_d;
  logic     done_q, done_d;

  // memory ports
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic              re;
  logic [IDX_W-1:0]  raddr;
  logic [WORD_W-1:0] rdata;

  logic [KEY_BITS-1:0]     rd_key;
  logic signed [CNT_W-1:0] rd_count;
  logic signed [CNT_W-1:0] sum;
  logic [31:0]             key_wide;
  logic                    hit;
  logic                    in_exempt;

  kct_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_key   = rdata[WORD_W-1:CNT_W];
  assign rd_count = rdata[CNT_W-1:0];
  assign sum      = sat_add(rd_count, amt_q);
  assign hit      = cvld_q && (rd_key == key_q);

  // keys compare on their low KEY_BITS bits
  assign key_wide  = 32'(item_i.key);
  assign in_exempt = item_i.exempt &&
                     ((item_i.cmd == CMD_ADD) || (item_i.cmd == CMD_LOOKUP));

  always_comb begin
    state_d = state_q;
    occ_d   = occ_q;
    ridx_d  = ridx_q;
    cidx_d  = cidx_q;
    cvld_d  = 1'b0;
    cmd_d   = cmd_q;
    key_d   = key_q;
    amt_d   = amt_q;
    res_d   = res_q;
    done_d  = 1'b0;
    we      = 1'b0;
    waddr   = cidx_q;
    wdata   = {key_q, sum};
    re      = 1'b0;
    raddr   = ridx_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d = item_i.cmd;
          key_d = key_wide[KEY_BITS-1:0];
          amt_d = item_i.amount;
          res_d = '{count: '0, found: 1'b0, status: STAT_DONE};
          if (in_exempt) begin
            res_d.status = STAT_EXEMPT;
            done_d       = 1'b1;
          end else if (item_i.cmd == CMD_RSVD) begin
            done_d = 1'b1;
          end else begin
            ridx_d  = '0;
            state_d = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        if (hit) begin
          res_d.found = 1'b1;
          if (cmd_q == CMD_ADD) begin
            // update in place
            we          = 1'b1;
            waddr       = cidx_q;
            wdata       = {key_q, sum};
            res_d.count = sum;
            done_d      = 1'b1;
            state_d     = S_IDLE;
          end else if (cmd_q == CMD_LOOKUP) begin
            res_d.count = rd_count;
            done_d      = 1'b1;
            state_d     = S_IDLE;
          end else begin
            // remove: move later entries down one slot
            ridx_d  = OCC_W'(cidx_q) + OCC_W'(1);
            state_d = S_SHIFT;
          end
        end else if (!cvld_q && (ridx_q >= occ_q)) begin
          // key absent
          if (cmd_q == CMD_ADD) begin
            if (occ_q == OCC_W'(ENTRIES)) begin
              res_d.status = STAT_FULL;
            end else begin
              we          = 1'b1;
              waddr       = occ_q[IDX_W-1:0];
              wdata       = {key_q, CNT_W'(amt_q)};
              occ_d       = occ_q + OCC_W'(1);
              res_d.count = CNT_W'(amt_q);
            end
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (ridx_q < occ_q) begin
          re     = 1'b1;
          cvld_d = 1'b1;
          cidx_d = ridx_q[IDX_W-1:0];
          ridx_d = ridx_q + OCC_W'(1);
        end
      end

      S_SHIFT: begin
        if (cvld_q) begin
          we    = 1'b1;
          waddr = cidx_q - IDX_W'(1);
          wdata = rdata;
        end
        if (ridx_q < occ_q) begin
          re     = 1'b1;
          cvld_d = 1'b1;
          cidx_d = ridx_q[IDX_W-1:0];
          ridx_d = ridx_q + OCC_W'(1);
        end else if (!cvld_q) begin
          occ_d   = occ_q - OCC_W'(1);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      cvld_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      cvld_q  <= cvld_d;
      done_q  <= done_d;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    ridx_q <= ridx_d;
    cidx_q <= cidx_d;
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    amt_q  <= amt_d;
    res_q  <= res_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[hdl/kct_checker.sv]
// Port-level checker for the keyed counter table, bound to the top level.
module kct_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input kct_pkg::kct_in_t  item_i,
  input logic              done_o,
  input kct_pkg::kct_out_t result_o
);

  import kct_pkg::*;

  // a result never shows while the sequencer is still working
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // exempt add or lookup answers in the next cycle with zero count
  a_exempt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && item_i.exempt &&
     ((item_i.cmd == CMD_ADD) || (item_i.cmd == CMD_LOOKUP)))
    |=> (done_o && !busy_o && (result_o.status == STAT_EXEMPT) &&
         (result_o.count == '0) && !result_o.found))
    else $error("exempt command not answered at once");

  // unused command code finishes at once and changes nothing
  a_rsvd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (item_i.cmd == CMD_RSVD))
    |=> (done_o && (result_o.status == STAT_DONE) && !result_o.found &&
         (result_o.count == '0)))
    else $error("unused command not answered at once");

  // a full-table report carries neither a count nor a hit
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == STAT_FULL)) |-> (!result_o.found &&
                                                    (result_o.count == '0)))
    else $error("full report with count or hit");

endmodule

bind keyed_counter_table_top kct_checker u_kct_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);

[verif/keyed_counter_table_top_tb.sv]
// Self-checking testbench for keyed_counter_table_top: directed table and random traffic.
module keyed_counter_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kct_pkg::*;

  localparam int unsigned TBL_DEPTH  = ENTRIES_DEF;
  // Longest search plus compaction, with margin, for the quiet time at the end.
  localparam int unsigned DRAIN_CYCS = 2 * TBL_DEPTH + 16;
  localparam int unsigned RAND_ITEMS = 530;
  localparam int unsigned MAX_REPORTS = 40;

  // One row of the directed table: the command, and optionally a typed-in answer.
  typedef struct {
    kct_in_t  stim;
    bit       typed;
    kct_out_t want;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  kct_in_t  item_i;
  logic     done_o;
  kct_out_t result_o;

  // Shadow copy of the table: keys and counts in insertion order, plus fill level.
  logic [KEY_W-1:0]        tbl_key   [TBL_DEPTH];
  logic signed [CNT_W-1:0] tbl_count [TBL_DEPTH];
  int unsigned             tbl_fill;

  kct_out_t    answer_q [$];   // answers still owed by the block, oldest first
  kct_out_t    last_answer;    // predicted answer of the most recent transfer
  int unsigned mismatches;
  int unsigned full_seen;      // adds that found the table full

  keyed_counter_table_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop far past the slowest legal run.
  initial begin
    #(64'd50_000_000);
    $display("status: fail");
    $finish;
  end

  // Apply one command to the shadow table and return the answer it must produce.
  function automatic kct_out_t table_apply(kct_in_t it);
    kct_out_t ans;
    int       slot;
    longint   sum;
    ans  = '0;
    slot = -1;
    if (it.cmd == CMD_RSVD) begin
      return ans;
    end
    // Exempt only silences add and lookup; a remove goes ahead regardless.
    if (it.exempt && it.cmd != CMD_REMOVE) begin
      ans.status = STAT_EXEMPT;
      return ans;
    end
    for (int i = 0; i < int'(tbl_fill); i++) begin
      if (slot < 0 && tbl_key[i] == it.key) slot = i;
    end
    case (it.cmd)
      CMD_ADD: begin
        if (slot >= 0) begin
          // Clamp the running count to the signed 32-bit range.
          sum = longint'(tbl_count[slot]) + longint'(it.amount);
          if (sum > longint'(COUNT_MAX)) sum = longint'(COUNT_MAX);
          if (sum < longint'(COUNT_MIN)) sum = longint'(COUNT_MIN);
          tbl_count[slot] = CNT_W'(sum);
          ans.count = tbl_count[slot];
          ans.found = 1'b1;
        end else if (tbl_fill >= TBL_DEPTH) begin
          ans.status = STAT_FULL;
        end else begin
          tbl_key[tbl_fill]   = it.key;
          tbl_count[tbl_fill] = CNT_W'(it.amount);
          ans.count = tbl_count[tbl_fill];
          tbl_fill++;
        end
      end
      CMD_LOOKUP: begin
        if (slot >= 0) begin
          ans.count = tbl_count[slot];
          ans.found = 1'b1;
        end
      end
      default: begin
        // Remove: close the gap by moving every later entry down one slot.
        if (slot >= 0) begin
          ans.found = 1'b1;
          for (int i = slot; i + 1 < int'(tbl_fill); i++) begin
            tbl_key[i]   = tbl_key[i + 1];
            tbl_count[i] = tbl_count[i + 1];
          end
          tbl_fill--;
        end
      end
    endcase
    return ans;
  endfunction

  function automatic dir_row_t mk_row(logic [1:0] cmd, logic [KEY_W-1:0] key, int amt,
                                      bit ex, bit typed, int cnt, bit fnd, logic [1:0] st);
    dir_row_t row;
    row.stim.cmd    = cmd;
    row.stim.key    = key;
    row.stim.amount = AMT_W'(amt);
    row.stim.exempt = ex;
    row.typed       = typed;
    row.want.count  = CNT_W'(cnt);
    row.want.found  = fnd;
    row.want.status = st;
    return row;
  endfunction

  // Idle length between transfers: mostly none or short, now and then long.
  function automatic int unsigned pick_gap(bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one command and hold it until it transfers (start high, busy low at an
  // edge). The answer is predicted at the transfer edge, so the queue keeps order.
  // start_i is left high; the caller lowers it only when a gap follows.
  task automatic send_cmd(kct_in_t it, bit typed, kct_out_t want);
    item_i  <= it;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    last_answer = table_apply(it);
    if (last_answer.status == STAT_FULL) full_seen++;
    answer_q.push_back(typed ? want : last_answer);
  endtask

  task automatic idle_for(int unsigned cycles);
    if (cycles != 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Drop the command request and wait until every owed answer has come back.
  task automatic drain_answers();
    start_i <= 1'b0;
    do @(posedge clk_i); while (answer_q.size() != 0);
  endtask

  // Result checker: done_o is a one-cycle pulse that the block cannot hold, so
  // take it at the edge that ends that cycle and compare with the oldest answer.
  always @(posedge clk_i) begin
    kct_out_t want;
    if (rst_ni && done_o) begin
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none actual count %0d found %0b status %0d",
                   $time, result_o.count, result_o.found, result_o.status);
      end else begin
        want = answer_q.pop_front();
        if (result_o.count !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: count mismatch, expected %0d actual %0d",
                     $time, want.count, result_o.count);
        end
        if (result_o.found !== want.found) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, want.found, result_o.found);
        end
        if (result_o.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, result_o.status);
        end
      end
    end
  end

  initial begin
    dir_row_t    rows [$];
    kct_in_t     it;
    kct_out_t    none;
    int unsigned counted;
    int unsigned r;
    bit          filling;
    bit          burst;

    none       = '0;
    mismatches = 0;
    full_seen  = 0;
    tbl_fill   = 0;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    item_i     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Typed answers only where they are obvious; the rest go
    // through the shadow table.
    rows.push_back(mk_row(CMD_LOOKUP, 20'h12345, 0, 0, 1, 0, 0, STAT_DONE));
    rows.push_back(mk_row(CMD_REMOVE, 20'h12345, 0, 0, 1, 0, 0, STAT_DONE));
    rows.push_back(mk_row(CMD_RSVD,   20'h00001, 5, 0, 1, 0, 0, STAT_DONE));
    rows.push_back(mk_row(CMD_ADD,    20'h00000, 32767, 1, 1, 0, 0, STAT_EXEMPT));
    rows.push_back(mk_row(CMD_LOOKUP, 20'h00000, 0, 1, 1, 0, 0, STAT_EXEMPT));
    rows.push_back(mk_row(CMD_ADD,    20'h00000, 32767, 0, 1, 32767, 0, STAT_DONE));
    rows.push_back(mk_row(CMD_ADD,    20'hFFFFF, -32768, 0, 1, -32768, 0, STAT_DONE));
    rows.push_back(mk_row(CMD_ADD,    20'h00000, 32767, 0, 1, 65534, 1, STAT_DONE));
    rows.push_back(mk_row(CMD_LOOKUP, 20'hFFFFF, 0, 0, 1, -32768, 1, STAT_DONE));
    rows.push_back(mk_row(CMD_ADD,    20'h55555, 0, 0, 0, 0, 0, STAT_DONE));
    rows.push_back(mk_row(CMD_ADD,    20'hAAAAA, -1, 0, 0, 0, 0, STAT_DONE));
    rows.push_back(mk_row(CMD_ADD,    20'h55555, -32768, 0, 0, 0, 0, STAT_DONE));
    // Exempt has no effect on remove: the entry goes and later ones move down.
    rows.push_back(mk_row(CMD_REMOVE, 20'h55555, 0, 1, 1, 0, 1, STAT_DONE));
    rows.push_back(mk_row(CMD_LOOKUP, 20'hAAAAA, 0, 0, 0, 0, 0, STAT_DONE));
    rows.push_back(mk_row(CMD_LOOKUP, 20'h55555, 0, 0, 1, 0, 0, STAT_DONE));
    rows.push_back(mk_row(CMD_ADD,    20'hAAAAA, 1, 0, 0, 0, 0, STAT_DONE));
    rows.push_back(mk_row(CMD_RSVD,   20'hFFFFF, -1, 1, 1, 0, 0, STAT_DONE));
    rows.push_back(mk_row(CMD_REMOVE, 20'hAAAAA, 0, 0, 1, 0, 1, STAT_DONE));
    rows.push_back(mk_row(CMD_REMOVE, 20'hAAAAA, 0, 0, 1, 0, 0, STAT_DONE));
    rows.push_back(mk_row(CMD_LOOKUP, 20'h00000, 0, 0, 0, 0, 0, STAT_DONE));
    foreach (rows[i]) begin
      send_cmd(rows[i].stim, rows[i].typed, rows[i].want);
      idle_for(pick_gap(1'b0));
    end

    // Hold off until the directed answers are all in.
    drain_answers();

    // Random traffic. The fill phase is mostly adds of new keys so the table
    // reaches full and keeps hitting it; the churn phase mixes in many removes
    // of stored keys so compaction runs from every depth.
    counted = 0;
    filling = 1'b1;
    burst   = 1'b0;
    while (counted < RAND_ITEMS) begin
      if (filling && (counted >= 420 || full_seen >= 12)) begin
        drain_answers();
        filling = 1'b0;
      end
      if (counted % 32 == 0) burst = ($urandom_range(0, 3) == 0);

      r = $urandom_range(0, 99);
      if (filling)
        it.cmd = r < 90 ? CMD_ADD : r < 94 ? CMD_LOOKUP : r < 98 ? CMD_REMOVE : CMD_RSVD;
      else
        it.cmd = r < 35 ? CMD_ADD : r < 60 ? CMD_LOOKUP : r < 95 ? CMD_REMOVE : CMD_RSVD;

      // Reuse a stored key for hits, otherwise draw any key.
      if (tbl_fill != 0 && $urandom_range(0, 99) < (filling ? 10 : 65))
        it.key = tbl_key[$urandom_range(0, tbl_fill - 1)];
      else
        it.key = KEY_W'($urandom());

      r = $urandom_range(0, 19);
      it.amount = r == 0 ? 16'sh7fff : r == 1 ? 16'sh8000 : AMT_W'($urandom());
      it.exempt = ($urandom_range(0, 99) < 8);

      counted++;

      send_cmd(it, 1'b0, none);
      idle_for(pick_gap(burst));
    end

    // Wait for the last answers, then stay quiet long enough to catch strays.
    drain_answers();
    repeat (DRAIN_CYCS) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
